@@ design/lis_pkg.sv @@
// Shared constants, types and byte classification for the identifier scanner.
`default_nettype none

package lis_pkg;

  localparam longint unsigned SOURCE_BYTES_DEFAULT = 64'd16777216;
  localparam int POS_W       = 24;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;

  // operation kinds passed from front to back
  localparam logic [1:0] OP_JUDGE  = 2'd0;
  localparam logic [1:0] OP_FLUSH  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  avail;   // bytes of real text in the lookahead, 0..4
    logic [31:0] bytes;   // byte under judgement in bits 7..0
  } op_t;

  function automatic logic is_first(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
           c == CH_UNDER || c == CH_DOLLAR;
  endfunction

  function automatic logic is_mid(input logic [7:0] c);
    return is_first(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

`default_nettype wire

@@ design/lis_in_if.sv @@
// Input channel: one source byte per word.
`default_nettype none

interface lis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;

  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

`default_nettype wire

@@ design/lis_out_if.sv @@
// Result channel: one identifier report per word.
`default_nettype none

interface lis_out_if;
  logic        valid;
  logic        ready;
  logic        ident_found;
  logic [23:0] ident_start;
  logic [23:0] ident_length;
  logic [23:0] ident_line;
  logic        run_last;

  modport source (output valid, ident_found, ident_start, ident_length, ident_line,
                  run_last, input ready);
  modport sink   (input valid, ident_found, ident_start, ident_length, ident_line,
                  run_last, output ready);
endinterface

`default_nettype wire

@@ design/lis_front.sv @@
// Front end: lookahead window and flush sequencing into judge operations.
`default_nettype none

module lis_front import lis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  lis_in_if.sink    src,
  output op_t       push_op,
  output logic      push_valid,
  input  wire logic q_full
);

  logic [23:0] win;
  logic [1:0]  fill;
  logic        flushing;
  logic [31:0] fl_buf;
  logic [2:0]  fl_avail;
  logic [31:0] cur;
  logic        accept;

  assign src.ready = !flushing && !q_full;
  assign accept    = src.valid && src.ready;

  // window with the new byte placed after the pending ones
  always_comb begin
    unique case (fill)
      2'd0:    cur = {24'd0, src.source_byte};
      2'd1:    cur = {16'd0, src.source_byte, win[7:0]};
      2'd2:    cur = {8'd0, src.source_byte, win[15:0]};
      default: cur = {src.source_byte, win};
    endcase
  end

  always_comb begin
    if (flushing) begin
      push_valid    = 1'b1;
      push_op.kind  = (fl_avail == 3'd0) ? OP_FINISH : OP_FLUSH;
      push_op.avail = fl_avail;
      push_op.bytes = fl_buf;
    end else begin
      push_valid    = accept && !src.end_of_source && (fill == 2'd3);
      push_op.kind  = OP_JUDGE;
      push_op.avail = 3'd4;
      push_op.bytes = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= 2'd0;
      flushing <= 1'b0;
    end else if (accept) begin
      if (src.end_of_source) begin
        fl_buf   <= cur;
        fl_avail <= {1'b0, fill} + 3'd1;
        flushing <= 1'b1;
        fill     <= 2'd0;
      end else if (fill == 2'd3) begin
        win <= cur[31:8];
      end else begin
        win  <= cur[23:0];
        fill <= fill + 2'd1;
      end
    end else if (flushing && !q_full) begin
      // one judge per pending byte, then the closing step
      if (fl_avail == 3'd0) begin
        flushing <= 1'b0;
      end else begin
        fl_buf   <= {8'd0, fl_buf[31:8]};
        fl_avail <= fl_avail - 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/lis_queue.sv @@
// Short operation queue between front and back.
`default_nettype none

module lis_queue import lis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output logic      op_valid,
  output op_t       op
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

  op_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == DEPTH_CNT);
  assign op_valid = (count != '0);
  assign op       = mem[rd_ptr];
  assign do_push  = push_valid && !full;
  assign do_pop   = pop && op_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ design/lis_back.sv @@
// Back end: comment and identifier tracking, counters and result register.
`default_nettype none

module lis_back import lis_pkg::*; #(
  parameter longint unsigned SOURCE_BYTES = SOURCE_BYTES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic op_valid,
  input  wire op_t  op,
  output logic      pop,
  lis_out_if.source res
);

  localparam longint unsigned LIMIT   = SOURCE_BYTES - 64'd1;
  localparam longint unsigned POS_CAP = (64'd1 << POS_W) - 64'd1;
  localparam logic [POS_W-1:0] POS_MAX = (LIMIT < POS_CAP) ? LIMIT[POS_W-1:0]
                                                           : {POS_W{1'b1}};

  // scanner state
  logic [1:0]       skip;
  logic             blk;
  logic             inl;
  logic             prev;
  logic             ident;
  logic [POS_W-1:0] name_start;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] lc;

  // report held back during a flush so the last one can carry run_last
  logic             pend_valid;
  logic [POS_W-1:0] pend_start;
  logic [POS_W-1:0] pend_len;
  logic [POS_W-1:0] pend_line;

  logic             out_valid;
  logic             out_found;
  logic [POS_W-1:0] out_start;
  logic [POS_W-1:0] out_len;
  logic [POS_W-1:0] out_line;
  logic             out_last;

  // judge results
  logic [7:0]       c, b1, b2, b3;
  logic             mid, first, m4, m2, handled, rep;
  logic [1:0]       skip_n;
  logic             blk_n, inl_n, prev_n, ident_n;
  logic [POS_W-1:0] start_n, lc_n, pos_n, rep_len;
  logic             fire, hold;

  always_comb begin
    c     = op.bytes[7:0];
    b1    = op.bytes[15:8];
    b2    = op.bytes[23:16];
    b3    = op.bytes[31:24];
    mid   = is_mid(c);
    first = is_first(c);
    m4    = !inl && (op.avail >= 3'd4) && c == CH_DASH && b1 == CH_DASH &&
            b2 == CH_LBRACK && b3 == CH_LBRACK;
    m2    = (op.avail >= 3'd2) && c == CH_RBRACK && b1 == CH_RBRACK;
    skip_n  = skip;
    blk_n   = blk;
    inl_n   = inl;
    prev_n  = prev;
    ident_n = ident;
    start_n = name_start;
    lc_n    = lc;
    handled = 1'b0;
    rep     = 1'b0;
    pos_n   = (pos < POS_MAX) ? pos + 1'b1 : pos;
    rep_len = pos - name_start;
    if (skip != 2'd0) begin
      skip_n = skip - 2'd1;
    end else begin
      if (m4) begin
        blk_n   = 1'b1;
        skip_n  = 2'd3;
        handled = 1'b1;
      end else if (m2) begin
        blk_n   = 1'b0;
        skip_n  = 2'd1;
        handled = 1'b1;
      end else begin
        if ((op.avail >= 3'd2) && c == CH_DASH && b1 == CH_DASH) inl_n = 1'b1;
        if (c == CH_LF || c == CH_CR) inl_n = 1'b0;
        if (c == CH_LF && lc != {POS_W{1'b1}}) lc_n = lc + 1'b1;
        handled = inl_n || blk_n;
      end
      if (ident && !mid) begin
        rep     = 1'b1;
        ident_n = 1'b0;
      end
      if (handled) begin
        if (rep) prev_n = 1'b1;
      end else begin
        if (!ident_n && first && prev) begin
          start_n = pos;
          ident_n = 1'b1;
        end
        prev_n = !mid;
      end
    end
  end

  assign fire = op_valid && (!out_valid || res.ready);
  // finish with both a held report and an open identifier takes two steps
  assign hold = (op.kind == OP_FINISH) && ident && pend_valid;
  assign pop  = fire && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip       <= 2'd0;
      blk        <= 1'b0;
      inl        <= 1'b0;
      prev       <= 1'b1;
      ident      <= 1'b0;
      name_start <= '0;
      pos        <= '0;
      lc         <= POS_W'(1);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && res.ready) out_valid <= 1'b0;
      if (fire) begin
        unique case (op.kind)
          OP_JUDGE, OP_FLUSH: begin
            skip       <= skip_n;
            blk        <= blk_n;
            inl        <= inl_n;
            prev       <= prev_n;
            ident      <= ident_n;
            name_start <= start_n;
            pos        <= pos_n;
            lc         <= lc_n;
            if (rep) begin
              if (op.kind == OP_JUDGE) begin
                out_valid <= 1'b1;
                out_found <= 1'b1;
                out_start <= name_start;
                out_len   <= rep_len;
                out_line  <= lc_n;
                out_last  <= 1'b0;
              end else begin
                if (pend_valid) begin
                  out_valid <= 1'b1;
                  out_found <= 1'b1;
                  out_start <= pend_start;
                  out_len   <= pend_len;
                  out_line  <= pend_line;
                  out_last  <= 1'b0;
                end
                pend_valid <= 1'b1;
                pend_start <= name_start;
                pend_len   <= rep_len;
                pend_line  <= lc_n;
              end
            end
          end
          OP_FINISH: begin
            out_valid <= 1'b1;
            if (hold) begin
              out_found  <= 1'b1;
              out_start  <= pend_start;
              out_len    <= pend_len;
              out_line   <= pend_line;
              out_last   <= 1'b0;
              pend_valid <= 1'b0;
            end else begin
              out_last <= 1'b1;
              if (ident) begin
                out_found <= 1'b1;
                out_start <= name_start;
                out_len   <= rep_len;
                out_line  <= lc;
              end else if (pend_valid) begin
                out_found <= 1'b1;
                out_start <= pend_start;
                out_len   <= pend_len;
                out_line  <= pend_line;
              end else begin
                out_found <= 1'b0;
                out_start <= '0;
                out_len   <= '0;
                out_line  <= '0;
              end
              // run ends: back to reset state
              skip       <= 2'd0;
              blk        <= 1'b0;
              inl        <= 1'b0;
              prev       <= 1'b1;
              ident      <= 1'b0;
              name_start <= '0;
              pos        <= '0;
              lc         <= POS_W'(1);
              pend_valid <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.ident_found  = out_found;
  assign res.ident_start  = out_start;
  assign res.ident_length = out_len;
  assign res.ident_line   = out_line;
  assign res.run_last     = out_last;

endmodule

`default_nettype wire

@@ design/lua_identifier_scanner.sv @@
// Path: after the word that completes the byte's three-byte lookahead is accepted, the
// byte is written to the queue, then judged by the back end into the result register.
// Throughput: one byte per cycle, set by the single judge step in the back end, while
// results are taken. An end-of-source word holds off input while pending bytes flush.
// Reset: synchronous, active high; empties window, clears flags, counters and queue at once.
`default_nettype none

module lua_identifier_scanner import lis_pkg::*; #(
  parameter longint unsigned SOURCE_BYTES = SOURCE_BYTES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  lis_in_if.sink    src,
  lis_out_if.source res
);

  op_t  push_op;
  logic push_valid;
  logic q_full;
  op_t  op;
  logic op_valid;
  logic pop;

  lis_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src        (src),
    .push_op    (push_op),
    .push_valid (push_valid),
    .q_full     (q_full)
  );

  lis_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .op_valid   (op_valid),
    .op         (op)
  );

  lis_back #(
    .SOURCE_BYTES (SOURCE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .pop      (pop),
    .res      (res)
  );

endmodule

`default_nettype wire
